// ===== rtl/core/pfa_pkg.sv =====
// Package for the partition fit allocator: codes, constants and shared types.
// Used by pfa_ctrl, pfa_datapath and partition_fit_allocator_core.
package pfa_pkg;
  localparam int unsigned NumPartsDef     = 8;
  localparam int unsigned SlotsPerPartDef = 16;
  localparam int unsigned AddrWidthDef    = 16;
  localparam int unsigned TagWidthDef     = 16;
  localparam int unsigned TotalWidth      = 20;

  localparam logic [1:0] ActDefine  = 2'd0;
  localparam logic [1:0] ActAlloc   = 2'd1;
  localparam logic [1:0] ActRelease = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StNoTag   = 2'd2;
  localparam logic [1:0] StBadRng  = 2'd3;

  localparam logic [1:0] PolFirst = 2'd0;
  localparam logic [1:0] PolWorst = 2'd1;
  localparam logic [1:0] PolBest  = 2'd2;

  typedef struct packed {
    logic load;       // capture input item
    logic do_define;  // apply define
    logic pick_step;  // one partition of the policy scan
    logic slot_step;  // one slot of the chosen partition
    logic rel_step;   // one slot of the release scan
    logic commit;     // write allocation
    logic finish;     // load output register
  } pfa_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       pick_last;
    logic       slot_last;
    logic       rel_last;
    logic       slot_found;
    logic       part_found;
  } pfa_sts_t;
endpackage

// ===== rtl/core/pfa_ctrl.sv =====
// Controller state machine of the partition fit allocator.
// Depends on pfa_pkg; drives pfa_datapath through pfa_cmd_t.
module pfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_busy_i,
  input  pfa_pkg::pfa_sts_t sts_i,
  output pfa_pkg::pfa_cmd_t cmd_o
);
  import pfa_pkg::*;

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SDisp  = 6'b000010,
    SPick  = 6'b000100,
    SSlot  = 6'b001000,
    SRel   = 6'b010000,
    SDone  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = SDisp;
        end
      end
      SDisp: begin
        unique case (sts_i.action)
          ActDefine: begin
            cmd_o.do_define = 1'b1;
            state_d = SDone;
          end
          ActAlloc: state_d = SPick;
          ActRelease: state_d = SRel;
          default: state_d = SDone;
        endcase
      end
      SPick: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.pick_last) state_d = SSlot;
      end
      SSlot: begin
        if (!sts_i.part_found) begin
          state_d = SDone;
        end else begin
          cmd_o.slot_step = 1'b1;
          if (sts_i.slot_found) begin
            cmd_o.slot_step = 1'b0;
            cmd_o.commit    = 1'b1;
            state_d         = SDone;
          end else if (sts_i.slot_last) begin
            state_d = SDone;
          end
        end
      end
      SRel: begin
        cmd_o.rel_step = 1'b1;
        if (sts_i.rel_last) state_d = SDone;
      end
      SDone: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else         state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == SIdle) else $error("load outside idle");
  a_finish_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !out_busy_i) else $error("finish while output busy");
  a_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == SDisp) else $error("load not followed by dispatch");
`endif
endmodule

// ===== rtl/core/pfa_datapath.sv =====
// Datapath of the partition fit allocator: partition tables, slot memory,
// scan counters and result register. Depends on pfa_pkg.
module pfa_datapath #(
  parameter int unsigned NumParts     = pfa_pkg::NumPartsDef,
  parameter int unsigned SlotsPerPart = pfa_pkg::SlotsPerPartDef,
  parameter int unsigned AddrWidth    = pfa_pkg::AddrWidthDef,
  parameter int unsigned TagWidth     = pfa_pkg::TagWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pfa_pkg::pfa_cmd_t    cmd_i,
  output pfa_pkg::pfa_sts_t    sts_o,
  input  logic [1:0]           fit_policy_i,
  input  logic [1:0]           action_i,
  input  logic [2:0]           part_index_i,
  input  logic [AddrWidth-1:0] low_addr_i,
  input  logic [AddrWidth-1:0] high_addr_i,
  input  logic [TagWidth-1:0]  owner_tag_i,
  input  logic [AddrWidth-1:0] request_size_i,
  output logic [1:0]           status_o,
  output logic [2:0]           chosen_part_o,
  output logic [AddrWidth-1:0] alloc_start_o,
  output logic [AddrWidth:0]   alloc_end_o,
  output logic [pfa_pkg::TotalWidth-1:0] freed_total_o
);
  import pfa_pkg::*;

  localparam int unsigned PW = (NumParts > 1) ? $clog2(NumParts) : 1;
  localparam int unsigned SW = (SlotsPerPart > 1) ? $clog2(SlotsPerPart) : 1;
  localparam int unsigned SlotCount = NumParts * SlotsPerPart;
  localparam int unsigned IW = PW + SW;
  localparam logic [AddrWidth:0] AddrMax = {1'b0, {AddrWidth{1'b1}}};
  localparam logic [TotalWidth:0] TotMax = {1'b0, {TotalWidth{1'b1}}};

  logic [AddrWidth-1:0] part_low_q  [NumParts];
  logic [AddrWidth-1:0] part_cap_q  [NumParts];
  logic [AddrWidth-1:0] part_free_q [NumParts];
  logic [SlotCount-1:0] slot_valid_q;
  logic [TagWidth+AddrWidth-1:0] slot_mem [SlotCount];
  logic [TagWidth+AddrWidth-1:0] rd_q;

  logic [1:0]           action_q;
  logic [2:0]           pidx_q;
  logic [AddrWidth-1:0] lo_q, hi_q, req_q;
  logic [TagWidth-1:0]  tag_q;
  logic [1:0]           policy_q;

  logic [PW-1:0] pcnt_q;
  logic [PW-1:0] best_q;
  logic          bfound_q;
  logic [SW-1:0] scnt_q;
  logic [IW-1:0] rcnt_q;
  logic [PW-1:0] rpart_q;
  logic [SW-1:0] rslot_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic [PW-1:0] rd_part_q;
  logic          rel_done_q;
  logic          found_q;
  logic [TotalWidth-1:0] total_q;
  logic [1:0]    res_st_q;
  logic [AddrWidth-1:0] res_start_q;
  logic [AddrWidth:0]   res_end_q;

  logic [AddrWidth-1:0] cur_free;
  logic take;
  logic [IW-1:0] slot_idx;
  logic [AddrWidth-1:0] start_w;
  logic [PW-1:0] rd_part;
  logic [AddrWidth:0] nf_sum;
  logic [TotalWidth:0] tot_sum;
  logic hit;

  assign cur_free = part_free_q[pcnt_q];
  always_comb begin
    take = 1'b0;
    if (cur_free >= req_q) begin
      unique case (policy_q)
        PolWorst: take = !bfound_q || cur_free > part_free_q[best_q];
        PolBest:  take = !bfound_q || cur_free < part_free_q[best_q];
        default:  take = !bfound_q && cur_free != '0;
      endcase
    end
  end

  assign slot_idx = IW'(best_q) * IW'(SlotsPerPart) + IW'(scnt_q);
  assign start_w  = part_low_q[best_q] + part_cap_q[best_q] - part_free_q[best_q];
  assign rd_part  = rd_part_q;
  assign hit      = rd_vld_q && slot_valid_q[rd_idx_q] &&
                    rd_q[TagWidth+AddrWidth-1:AddrWidth] == tag_q;
  assign nf_sum   = {1'b0, part_free_q[rd_part]} + {1'b0, rd_q[AddrWidth-1:0]};
  assign tot_sum  = {1'b0, total_q} + (TotalWidth+1)'(rd_q[AddrWidth-1:0]);

  assign sts_o.action     = action_q;
  assign sts_o.pick_last  = pcnt_q == PW'(NumParts - 1);
  assign sts_o.slot_last  = scnt_q == SW'(SlotsPerPart - 1);
  assign sts_o.slot_found = !slot_valid_q[slot_idx];
  assign sts_o.part_found = bfound_q;
  assign sts_o.rel_last   = rel_done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= action_i; pidx_q <= part_index_i; lo_q <= low_addr_i;
      hi_q <= high_addr_i; tag_q <= owner_tag_i; req_q <= request_size_i;
      policy_q <= fit_policy_i;
    end
    if (cmd_i.commit) slot_mem[slot_idx] <= {tag_q, req_q};
    rd_q <= slot_mem[rcnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumParts; p++) begin
        part_low_q[p] <= '0; part_cap_q[p] <= '0; part_free_q[p] <= '0;
      end
      slot_valid_q <= '0;
      pcnt_q <= '0; best_q <= '0; bfound_q <= 1'b0; scnt_q <= '0;
      rcnt_q <= '0; rpart_q <= '0; rslot_q <= '0; rd_part_q <= '0;
      rd_vld_q <= 1'b0; rd_idx_q <= '0; rel_done_q <= 1'b0;
      found_q <= 1'b0; total_q <= '0; res_st_q <= StNoFit;
      res_start_q <= '0; res_end_q <= '0;
      status_o <= StOk; chosen_part_o <= '0; alloc_start_o <= '0;
      alloc_end_o <= '0; freed_total_o <= '0;
    end else begin
      if (cmd_i.load) begin
        pcnt_q <= '0; best_q <= '0; bfound_q <= 1'b0; scnt_q <= '0;
        rcnt_q <= '0; rpart_q <= '0; rslot_q <= '0;
        rd_vld_q <= 1'b0; rel_done_q <= 1'b0;
        found_q <= 1'b0; total_q <= '0; res_st_q <= StNoFit;
        res_start_q <= '0; res_end_q <= '0;
      end
      if (cmd_i.do_define) begin
        if (32'(pidx_q) >= NumParts || hi_q < lo_q) begin
          res_st_q <= StBadRng;
        end else begin
          part_low_q[pidx_q[PW-1:0]]  <= lo_q;
          part_cap_q[pidx_q[PW-1:0]]  <= hi_q - lo_q;
          part_free_q[pidx_q[PW-1:0]] <= hi_q - lo_q;
          for (int s = 0; s < SlotsPerPart; s++)
            slot_valid_q[IW'(pidx_q[PW-1:0]) * IW'(SlotsPerPart) + IW'(s)] <= 1'b0;
          res_st_q <= StOk;
        end
      end
      if (cmd_i.pick_step) begin
        if (take) begin
          best_q <= pcnt_q; bfound_q <= 1'b1;
        end
        if (!sts_o.pick_last) pcnt_q <= pcnt_q + 1'b1;
      end
      if (cmd_i.slot_step) scnt_q <= scnt_q + 1'b1;
      if (cmd_i.commit) begin
        slot_valid_q[slot_idx] <= 1'b1;
        part_free_q[best_q] <= part_free_q[best_q] - req_q;
        res_st_q    <= StOk;
        res_start_q <= start_w;
        res_end_q   <= {1'b0, start_w} + {1'b0, req_q};
      end
      if (cmd_i.rel_step) begin
        rd_vld_q <= !(rd_vld_q && rd_idx_q == IW'(SlotCount - 1)) &&
                    (rcnt_q < IW'(SlotCount - 1) || !rd_vld_q || rd_idx_q != rcnt_q);
        rd_idx_q  <= rcnt_q;
        rd_part_q <= rpart_q;
        if (rcnt_q != IW'(SlotCount - 1)) begin
          rcnt_q <= rcnt_q + 1'b1;
          if (rslot_q == SW'(SlotsPerPart - 1)) begin
            rslot_q <= '0;
            rpart_q <= rpart_q + 1'b1;
          end else begin
            rslot_q <= rslot_q + 1'b1;
          end
        end
        if (rd_vld_q && rd_idx_q == IW'(SlotCount - 1)) rel_done_q <= 1'b1;
        if (hit) begin
          part_free_q[rd_part] <= nf_sum > AddrMax ? nf_sum[AddrWidth-1:0] | '1
                                                   : nf_sum[AddrWidth-1:0];
          total_q <= tot_sum > TotMax ? '1 : tot_sum[TotalWidth-1:0];
          slot_valid_q[rd_idx_q] <= 1'b0;
          found_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        if (action_q == ActRelease) begin
          status_o <= (found_q || hit) ? StOk : StNoTag;
          freed_total_o <= total_q;
        end else begin
          status_o <= res_st_q;
          freed_total_o <= '0;
        end
        chosen_part_o <= (action_q == ActAlloc && res_st_q == StOk) ? 3'(best_q) : 3'd0;
        alloc_start_o <= res_start_q;
        alloc_end_o   <= res_end_q;
      end
    end
  end

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !slot_valid_q[slot_idx]) else $error("commit into used slot");
  a_commit_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> part_free_q[best_q] >= req_q) else $error("allocation exceeds free");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> slot_valid_q[$past(slot_idx)]) else $error("slot not marked");
`endif
endmodule

// ===== rtl/core/partition_fit_allocator_core.sv =====
// Partition fit allocator: manages up to NumParts address partitions and a
// table of allocation slots per partition.
// Channels: s_axis carries one item per transfer (action in tuser, the other
// fields in tdata); m_axis returns one result per item (status in tuser).
// The fit_policy register is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not enforce.
// Work per item: a define is applied in the dispatch state; an allocate runs
// the policy scan over all partitions, then the free slot search; a release
// scans the slot memory, read one entry a cycle. One item is in work at a time;
// s_axis_tready is high only while the controller waits for an item.
// Reset clears all partitions, all slot valid bits and sets first fit.
// A result waits in the output register while m_axis_tready is low; the
// next item may be accepted and worked, and its result is held back until
// the register is free.
// Depends on pfa_pkg, pfa_ctrl and pfa_datapath.
module partition_fit_allocator_core #(
  parameter int unsigned NumParts     = pfa_pkg::NumPartsDef,
  parameter int unsigned SlotsPerPart = pfa_pkg::SlotsPerPartDef,
  parameter int unsigned AddrWidth    = pfa_pkg::AddrWidthDef,
  parameter int unsigned TagWidth     = pfa_pkg::TagWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // part_index, low_addr, high_addr, owner_tag, request_size, zero fill
  input  logic [((3 + 4 * AddrWidth - AddrWidth + TagWidth + 7) / 8) * 8 - 1:0]
               s_axis_tdata,
  // action
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // chosen_part, alloc_start, alloc_end, freed_total, zero fill
  output logic [((3 + 2 * AddrWidth + 1 + pfa_pkg::TotalWidth + 7) / 8) * 8 - 1:0]
               m_axis_tdata,
  // status
  output logic [1:0] m_axis_tuser
);
  import pfa_pkg::*;

  localparam int unsigned InW  = 3 + 3 * AddrWidth + TagWidth;
  localparam int unsigned OutW = 3 + 2 * AddrWidth + 1 + TotalWidth;
  localparam int unsigned OutBusW = ((OutW + 7) / 8) * 8;

  pfa_cmd_t cmd;
  pfa_sts_t sts;
  logic [1:0] policy_q;
  logic out_vld_q;
  logic [1:0] st;
  logic [2:0] cp;
  logic [AddrWidth-1:0] as;
  logic [AddrWidth:0] ae;
  logic [TotalWidth-1:0] ft;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) policy_q <= PolFirst;
    else if (cfg_we_i) policy_q <= cfg_wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (cmd.finish) out_vld_q <= 1'b1;
    else if (m_axis_tready) out_vld_q <= 1'b0;
  end

  pfa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (out_vld_q && !m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfa_datapath #(
    .NumParts(NumParts), .SlotsPerPart(SlotsPerPart),
    .AddrWidth(AddrWidth), .TagWidth(TagWidth)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .fit_policy_i   (policy_q),
    .action_i       (s_axis_tuser),
    .part_index_i   (s_axis_tdata[2:0]),
    .low_addr_i     (s_axis_tdata[3 +: AddrWidth]),
    .high_addr_i    (s_axis_tdata[3 + AddrWidth +: AddrWidth]),
    .owner_tag_i    (s_axis_tdata[3 + 2 * AddrWidth +: TagWidth]),
    .request_size_i (s_axis_tdata[3 + 2 * AddrWidth + TagWidth +: AddrWidth]),
    .status_o       (st),
    .chosen_part_o  (cp),
    .alloc_start_o  (as),
    .alloc_end_o    (ae),
    .freed_total_o  (ft)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = st;
  assign m_axis_tdata  = OutBusW'({ft, ae, as, cp});

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !cmd.finish) else $error("accept during finish");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped under stall");
  a_in_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(out_vld_q && !m_axis_tready) && InW > 0)
    else $error("result overwrites pending output");
`endif
endmodule

// ===== tb/tb_partition_fit_allocator_core.sv =====
// Self-checking testbench for partition_fit_allocator_core: defines, allocations
// under every fit policy and releases, checked against an in-bench predictor.
// Depends on pfa_pkg and the core RTL.
module tb_partition_fit_allocator_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam int unsigned Parts = 8;
  localparam int unsigned Slots = 16;
  localparam logic [1:0] ActNone = 2'd3;
  localparam logic [1:0] PolUnused = 2'd3;
  localparam int unsigned IdleWait = 200;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned WatchLimit = 3000;

  typedef struct {
    logic [1:0]  status;
    logic [2:0]  part;
    logic [15:0] start;
    logic [16:0] stop;
    logic [19:0] freed;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  partition_fit_allocator_core dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [1:0]  policy;
  logic [15:0] p_low [Parts];
  logic [15:0] p_cap [Parts];
  logic [15:0] p_free [Parts];
  logic        s_valid [Parts*Slots];
  logic [15:0] s_owner [Parts*Slots];
  logic [15:0] s_size [Parts*Slots];

  outcome_t expected_q[$];
  int errors = 0, n_items = 0, n_results = 0, quiet_cycles = 0;
  bit hold_rx = 0, no_gaps = 0;
  logic [15:0] tag_pool [6];

  function automatic int choose_part(logic [15:0] req);
    int found = -1;
    for (int p = 0; p < Parts; p++) begin
      if (p_free[p] < req) continue;
      if (policy == PolWorst) begin
        if (found < 0 || p_free[p] > p_free[found]) found = p;
      end else if (policy == PolBest) begin
        if (found < 0 || p_free[p] < p_free[found]) found = p;
      end else if (p_free[p] != 0) begin
        return p;
      end
    end
    return found;
  endfunction

  function automatic outcome_t apply_item(logic [1:0] act, logic [2:0] idx,
      logic [15:0] lo, logic [15:0] hi, logic [15:0] tag, logic [15:0] req);
    outcome_t r;
    int p, slot;
    logic [19:0] sum;
    logic [16:0] nf;
    r = '{StNoFit, '0, '0, '0, '0};
    if (act == ActDefine) begin
      if (hi < lo) begin
        r.status = StBadRng;
      end else begin
        p_low[idx] = lo;
        p_cap[idx] = hi - lo;
        p_free[idx] = hi - lo;
        for (int s = 0; s < Slots; s++) s_valid[idx*Slots+s] = 1'b0;
        r.status = StOk;
      end
    end else if (act == ActAlloc) begin
      p = choose_part(req);
      slot = -1;
      if (p >= 0) begin
        for (int s = 0; s < Slots; s++) begin
          if (!s_valid[p*Slots+s]) begin
            slot = p*Slots+s;
            break;
          end
        end
      end
      if (slot >= 0) begin
        r.start = p_low[p] + p_cap[p] - p_free[p];
        s_valid[slot] = 1'b1;
        s_owner[slot] = tag;
        s_size[slot] = req;
        p_free[p] = p_free[p] - req;
        r.status = StOk;
        r.part = p[2:0];
        r.stop = {1'b0, r.start} + {1'b0, req};
      end
    end else if (act == ActRelease) begin
      sum = '0;
      r.status = StNoTag;
      for (int i = 0; i < Parts*Slots; i++) begin
        if (s_valid[i] && s_owner[i] == tag) begin
          nf = {1'b0, p_free[i/Slots]} + {1'b0, s_size[i]};
          p_free[i/Slots] = nf[16] ? 16'hffff : nf[15:0];
          sum = (21'(sum) + 21'(s_size[i]) > 21'hfffff) ? 20'hfffff
                                                       : sum + 20'(s_size[i]);
          s_valid[i] = 1'b0;
          r.status = StOk;
        end
      end
      if (r.status == StOk) r.freed = sum;
    end
    return r;
  endfunction

  task automatic send_item(logic [1:0] act, logic [2:0] idx, logic [15:0] lo,
      logic [15:0] hi, logic [15:0] tag, logic [15:0] req);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {5'b0, req, tag, hi, lo, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(apply_item(act, idx, lo, hi, tag, req));
    n_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic set_policy(logic [1:0] pol);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= pol;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    policy = pol;
  endtask

  task automatic report_mismatch(string what, logic [19:0] got, logic [19:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (rst_ni && m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result transfer", '0, '0);
      end else begin
        outcome_t e;
        e = expected_q.pop_front();
        if (m_axis_tuser != e.status)
          report_mismatch("status", 20'(m_axis_tuser), 20'(e.status));
        if (m_axis_tdata[2:0] != e.part)
          report_mismatch("chosen_part", 20'(m_axis_tdata[2:0]), 20'(e.part));
        if (m_axis_tdata[18:3] != e.start)
          report_mismatch("alloc_start", 20'(m_axis_tdata[18:3]), 20'(e.start));
        if (m_axis_tdata[35:19] != e.stop)
          report_mismatch("alloc_end", 20'(m_axis_tdata[35:19]), 20'(e.stop));
        if (m_axis_tdata[55:36] != e.freed)
          report_mismatch("freed_total", m_axis_tdata[55:36], e.freed);
      end
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("[partition_fit_allocator_core] ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 11);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx = 0;
      end else if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic test_define();
    for (int p = 0; p < Parts; p++)
      send_item(ActDefine, 3'(p), 16'(p*1000), 16'(p*1000 + 200 + p*50), '0, '0);
    send_item(ActDefine, 3'd3, 16'h0100, 16'h00ff, '0, '0);
    send_item(ActDefine, 3'd7, 16'hffff, 16'h0000, 16'hffff, 16'hffff);
    send_item(ActNone, 3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
  endtask

  task automatic test_policies();
    for (int pol = 0; pol < 4; pol++) begin
      set_policy(pol[1:0]);
      send_item(ActAlloc, '0, '0, '0, 16'(16'h00a0 + pol), 16'd120);
      send_item(ActAlloc, '0, '0, '0, 16'(16'h00b0 + pol), 16'd0);
      send_item(ActAlloc, '0, '0, '0, 16'h00c0, 16'hffff);
      send_item(ActRelease, '0, '0, '0, 16'(16'h00a0 + pol), '0);
    end
    send_item(ActRelease, '0, '0, '0, 16'h1234, '0);
  endtask

  task automatic test_slot_full();
    set_policy(PolFirst);
    send_item(ActDefine, 3'd0, 16'h0000, 16'hffff, '0, '0);
    for (int i = 0; i < Slots + 1; i++) send_item(ActAlloc, '0, '0, '0, 16'h0055, 16'd1);
    send_item(ActRelease, '0, '0, '0, 16'h0055, '0);
    send_item(ActRelease, '0, '0, '0, 16'h0055, '0);
  endtask

  task automatic test_backpressure();
    hold_rx = 1;
    for (int i = 0; i < 8; i++) send_item(ActAlloc, '0, '0, '0, tag_pool[i % 6], 16'd3);
  endtask

  task automatic random_item();
    int k;
    logic [15:0] lo, hi, tag;
    k = $urandom_range(0, 99);
    tag = ($urandom_range(0, 9) == 0) ? 16'($urandom) : tag_pool[$urandom_range(0, 5)];
    if (k < 6) begin
      lo = 16'($urandom);
      if ($urandom_range(0, 4) == 0) hi = 16'($urandom);
      else if (lo > 16'hfc00) hi = 16'hffff;
      else hi = lo + 16'($urandom_range(0, 1023));
      send_item(ActDefine, 3'($urandom), lo, hi, 16'($urandom), 16'($urandom));
    end else if (k < 65) begin
      send_item(ActAlloc, 3'($urandom), 16'($urandom), 16'($urandom), tag,
                ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80)));
    end else if (k < 97) begin
      send_item(ActRelease, 3'($urandom), 16'($urandom), 16'($urandom), tag,
                16'($urandom));
    end else begin
      send_item(ActNone, 3'($urandom), 16'($urandom), 16'($urandom), tag,
                16'($urandom));
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      set_policy(ph == 4 ? PolUnused : 2'($urandom_range(0, 2)));
      no_gaps = (ph == 2);
      for (int i = 0; i < 260; i++) random_item();
      no_gaps = 0;
    end
  endtask

  initial begin
    policy = PolFirst;
    for (int p = 0; p < Parts; p++) begin
      p_low[p] = '0;
      p_cap[p] = '0;
      p_free[p] = '0;
    end
    for (int i = 0; i < Parts*Slots; i++) s_valid[i] = 1'b0;
    for (int i = 0; i < 6; i++) tag_pool[i] = 16'($urandom);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_define();
    test_policies();
    test_slot_full();
    test_backpressure();
    test_random();
    drain();
    $display("Covered %0d items and %0d results across all fit policies,", n_items, n_results);
    $display("including redefinition, full slot tables, zero requests and a long output stall.");
    if (errors == 0) begin
      $display("[partition_fit_allocator_core] OK");
    end else begin
      $display("[partition_fit_allocator_core] ERROR");
    end
    $finish;
  end
endmodule
